// ===== rtl/rtt_pkg.sv =====
// Shared types and constants for the radix text-to-integer parser.
// Used by rtt_front, rtt_queue, rtt_back and radix_text_to_integer.
package rtt_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 6;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned NarrowW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CharW-1:0]  MINUS_CODE  = 8'h2D;
  localparam logic [CharW-1:0]  TERM_CODE   = 8'h00;
  localparam logic [DigitW-1:0] LETTER_BASE = 6'd10;
  localparam logic [RadixW-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RadixW-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RadixW-1:0] RADIX_RESET = 6'd10;

  localparam logic [CfgIdxW-1:0] CFG_RADIX = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDE  = 2'd1;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_MINUS,
    KIND_TERM
  } kind_e;

  // One classified byte: what the back end has to do with it.
  typedef struct packed {
    kind_e             kind;
    logic [DigitW-1:0] digit;
    logic              bad;
  } op_t;

endpackage

// ===== rtl/rtt_front.sv =====
// Front end: accepts text bytes, tracks the start of a string and
// classifies each byte into an op. Depends on rtt_pkg.
module rtt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [rtt_pkg::CharW-1:0] in_char_i,
  output logic                     op_valid_o,
  input  logic                     op_ready_i,
  output rtt_pkg::op_t             op_o
);

  logic at_start_q, at_start_d;
  logic accept;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i & op_ready_i;

  always_comb begin
    op_o.kind  = rtt_pkg::KIND_DIGIT;
    op_o.digit = '0;
    op_o.bad   = 1'b0;
    if (in_char_i == rtt_pkg::TERM_CODE) begin
      op_o.kind = rtt_pkg::KIND_TERM;
    end else if (at_start_q && in_char_i == rtt_pkg::MINUS_CODE) begin
      op_o.kind = rtt_pkg::KIND_MINUS;
    end else if (in_char_i >= 8'h30 && in_char_i <= 8'h39) begin
      op_o.digit = rtt_pkg::DigitW'(in_char_i - 8'h30);
    end else if (in_char_i >= 8'h61 && in_char_i <= 8'h7A) begin
      op_o.digit = rtt_pkg::LETTER_BASE + rtt_pkg::DigitW'(in_char_i - 8'h61);
    end else if (in_char_i >= 8'h41 && in_char_i <= 8'h5A) begin
      op_o.digit = rtt_pkg::LETTER_BASE + rtt_pkg::DigitW'(in_char_i - 8'h41);
    end else begin
      op_o.bad = 1'b1;
    end
  end

  // The next byte after a terminator opens a new string.
  always_comb begin
    at_start_d = at_start_q;
    if (accept) begin
      at_start_d = (in_char_i == rtt_pkg::TERM_CODE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
    end else begin
      at_start_q <= at_start_d;
    end
  end

endmodule

// ===== rtl/rtt_queue.sv =====
// Short queue of classified ops between front and back end.
// Depends on rtt_pkg.
module rtt_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  rtt_pkg::op_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output rtt_pkg::op_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtt_pkg::op_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/rtt_back.sv =====
// Back end: accumulates digits in the configured radix and formats the
// result into an output register on each terminator. Depends on rtt_pkg.
module rtt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rtt_pkg::RadixW-1:0] radix_i,
  input  logic                       wide_mode_i,
  input  logic                       op_valid_i,
  output logic                       op_ready_o,
  input  rtt_pkg::op_t               op_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rtt_pkg::ValueW-1:0] out_value_o,
  output logic                       out_error_o
);

  logic [rtt_pkg::ValueW-1:0] acc_q, acc_d;
  logic                       neg_q, neg_d;
  logic                       err_q, err_d;
  logic                       out_valid_q, out_valid_d;
  logic [rtt_pkg::ValueW-1:0] out_value_q, out_value_d;
  logic                       out_error_q, out_error_d;

  logic                       is_term, pop, load;
  logic                       bad_radix;
  logic [rtt_pkg::ValueW-1:0] signed_val, fmt_val;
  logic [rtt_pkg::ValueW-1:0] mac;

  assign is_term     = (op_i.kind == rtt_pkg::KIND_TERM);
  // Only a terminator needs room in the output register.
  assign op_ready_o  = !is_term || !out_valid_q || out_ready_i;
  assign pop         = op_valid_i & op_ready_o;
  assign load        = pop & is_term;
  assign bad_radix   = (radix_i < rtt_pkg::RADIX_MIN) || (radix_i > rtt_pkg::RADIX_MAX);
  assign mac         = acc_q * rtt_pkg::ValueW'(radix_i) + rtt_pkg::ValueW'(op_i.digit);
  assign signed_val  = neg_q ? (~acc_q + rtt_pkg::ValueW'(1)) : acc_q;
  assign fmt_val     = wide_mode_i ? signed_val :
                       {{(rtt_pkg::ValueW - rtt_pkg::NarrowW){signed_val[rtt_pkg::NarrowW-1]}},
                        signed_val[rtt_pkg::NarrowW-1:0]};

  always_comb begin
    acc_d = acc_q;
    neg_d = neg_q;
    err_d = err_q;
    if (pop) begin
      unique case (op_i.kind)
        rtt_pkg::KIND_TERM: begin
          acc_d = '0;
          neg_d = 1'b0;
          err_d = 1'b0;
        end
        rtt_pkg::KIND_MINUS: begin
          neg_d = 1'b1;
        end
        rtt_pkg::KIND_DIGIT: begin
          if (op_i.bad || (op_i.digit >= radix_i)) begin
            err_d = 1'b1;
          end else if (!err_q) begin
            acc_d = mac;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_error_d = out_error_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (bad_radix || err_q) begin
        out_value_d = '1;
        out_error_d = 1'b1;
      end else begin
        out_value_d = fmt_val;
        out_error_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_error_o = out_error_q;

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_error_q <= out_error_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/radix_text_to_integer.sv =====
// Radix text-to-integer parser, top level: configuration registers and
// the front end, op queue and back end. Depends on rtt_pkg, rtt_front,
// rtt_queue and rtt_back.
//
// Usage: text bytes stream in on s_axis (one byte in tdata). A zero byte
// ends a string; for it one result leaves on m_axis: tdata carries the
// 64-bit two's complement value, tuser bit 0 the error flag (value is all
// ones when the flag is set). Other bytes produce no result.
// The config channel writes radix (index 0, data bits 5:0) and wide mode
// (index 1, data bit 0); other indexes are ignored. Write only while idle.
// Throughput: one byte per cycle sustained while the op queue has room. The
// front end classifies a byte as it is accepted and pushes it into the op
// queue; the back end pops it from there, and a terminator's result is
// registered in the back end's output register before it shows on m_axis.
// Reset clears the string state (next byte is the first of a string),
// sets radix 10 and 32-bit mode. When m_axis stalls, the held result
// blocks only the next terminator; digits keep flowing until the op queue
// of QUEUE_DEPTH entries fills, then s_axis_tready drops.
module radix_text_to_integer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [0:0]  m_axis_tuser,   // [0] error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  logic [rtt_pkg::RadixW-1:0] radix_q, radix_d;
  logic                       wide_q, wide_d;
  logic                       cfg_we;

  logic         f_valid, f_ready;
  rtt_pkg::op_t f_op;
  logic         b_valid, b_ready;
  rtt_pkg::op_t b_op;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    radix_d = radix_q;
    wide_d  = wide_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        rtt_pkg::CFG_RADIX: radix_d = cfg_data_i;
        rtt_pkg::CFG_WIDE:  wide_d  = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rtt_pkg::RADIX_RESET;
      wide_q  <= 1'b0;
    end else begin
      radix_q <= radix_d;
      wide_q  <= wide_d;
    end
  end

  rtt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  rtt_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_op)
  );

  rtt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .wide_mode_i (wide_q),
    .op_valid_i  (b_valid),
    .op_ready_o  (b_ready),
    .op_i        (b_op),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_error_o (m_axis_tuser[0])
  );

endmodule
